FILE: rtl/cng_pkg.sv
package cng_pkg;

  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int MAX_GRAM_DEF      = 3;
  localparam int COUNT_BITS_DEF    = 32;

  localparam int CHAR_W  = 21;
  localparam int GRAM_W  = 3 * CHAR_W;
  localparam int IDX_W   = 10;
  localparam int OUT_CNT_W = 32;
  localparam int USED_OUT_W = 11;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_READ = 1'b1;

  // One classified item as the front part hands it to the back part.
  typedef struct packed {
    logic              op;
    logic              count_en;
    logic [CHAR_W-1:0] g0;
    logic [CHAR_W-1:0] g1;
    logic [CHAR_W-1:0] g2;
    logic              susp;
    logic [IDX_W-1:0]  read_index;
  } cng_item_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_RDWAIT = 3'b100
  } cng_state_t;

endpackage

FILE: rtl/cng_ram.sv
module cng_ram import cng_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/cng_front.sv
module cng_front import cng_pkg::*; #(
  parameter int MAX_GRAM = MAX_GRAM_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  input  logic              accept,
  input  logic              in_opcode,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic              in_char_suspect,
  input  logic              in_file_start,
  input  logic [IDX_W-1:0]  in_read_index,
  output cng_item_t         item
);

  localparam logic [1:0] MAXG = 2'(MAX_GRAM);

  logic [1:0]        gram_len_r;
  logic [CHAR_W-1:0] rc0_r, rc1_r;
  logic              rs0_r, rs1_r;
  logic [1:0]        cif_r, cif_nxt;
  logic [1:0]        n, have;

  always_comb begin
    n = gram_len_r;
    if (n == 2'd0) n = 2'd1;
    if (n > MAXG) n = MAXG;
    have = in_file_start ? 2'd0 : cif_r;
    cif_nxt = (have == 2'd3) ? 2'd3 : have + 2'd1;

    item = '0;
    item.op = in_opcode;
    item.read_index = in_read_index;
    item.count_en = ({1'b0, have} + 3'd1) >= {1'b0, n};
    case (n)
      2'd2: begin
        item.g0 = rc0_r;
        item.g1 = in_char_code;
        item.susp = in_char_suspect | rs0_r;
      end
      2'd3: begin
        item.g0 = rc1_r;
        item.g1 = rc0_r;
        item.g2 = in_char_code;
        item.susp = in_char_suspect | rs0_r | rs1_r;
      end
      default: begin
        item.g0 = in_char_code;
        item.susp = in_char_suspect;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gram_len_r <= 2'd1;
      rc0_r <= '0;
      rc1_r <= '0;
      rs0_r <= 1'b0;
      rs1_r <= 1'b0;
      cif_r <= 2'd0;
    end else begin
      if (cfg_we) gram_len_r <= cfg_wdata;
      if (accept && in_opcode == OP_CHAR) begin
        rc1_r <= rc0_r;
        rs1_r <= rs0_r;
        rc0_r <= in_char_code;
        rs0_r <= in_char_suspect;
        cif_r <= cif_nxt;
      end
    end
  end

endmodule

FILE: rtl/cng_queue.sv
module cng_queue import cng_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cng_item_t push_item,
  input  logic      pop,
  output cng_item_t head,
  output logic      empty,
  output logic      full
);

  cng_item_t  slots_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign head  = slots_r[rp_r];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (push) slots_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/cng_back.sv
module cng_back import cng_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cng_item_t             head,
  input  logic                  empty,
  output logic                  pop,
  output logic                  out_strobe,
  output logic                  out_entry_present,
  output logic [CHAR_W-1:0]     out_gram_first,
  output logic [CHAR_W-1:0]     out_gram_second,
  output logic [CHAR_W-1:0]     out_gram_third,
  output logic [OUT_CNT_W-1:0]  out_occurrences,
  output logic [OUT_CNT_W-1:0]  out_suspect_occurrences,
  output logic [OUT_CNT_W-1:0]  out_grand_total,
  output logic [OUT_CNT_W-1:0]  out_grand_suspect,
  output logic [USED_OUT_W-1:0] out_distinct_used,
  output logic                  out_dropped_full
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int UW = $clog2(TABLE_ENTRIES + 1);
  localparam int CW = (UW > IDX_W) ? UW : IDX_W;
  localparam int WW = GRAM_W + 2 * COUNT_BITS;
  localparam logic [UW-1:0] FULL_CNT = UW'(TABLE_ENTRIES);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  cng_state_t state_r, state_nxt;
  cng_item_t  cur_r, cur_nxt, itm;
  logic [AW-1:0] scan_r, scan_nxt;
  logic [UW-1:0] used_r, used_nxt;
  logic [COUNT_BITS-1:0] sum_r, sum_nxt, ssum_r, ssum_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [WW-1:0] wdata, rdata;

  logic                  strobe_r, strobe_nxt;
  logic                  pres_r, pres_nxt, drop_r, drop_nxt;
  logic [GRAM_W-1:0]     gram_r, gram_nxt;
  logic [COUNT_BITS-1:0] occ_r, occ_nxt, socc_r, socc_nxt;

  logic [GRAM_W-1:0]     r_chars, i_chars;
  logic [COUNT_BITS-1:0] r_cnt, r_scnt, n_cnt, n_scnt;
  logic [CW-1:0]         idx_ext, used_ext;
  logic                  used_zero;

  cng_ram #(.WIDTH(WW), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign r_chars = rdata[GRAM_W-1:0];
  assign r_cnt   = rdata[GRAM_W +: COUNT_BITS];
  assign r_scnt  = rdata[GRAM_W + COUNT_BITS +: COUNT_BITS];
  assign idx_ext  = CW'(head.read_index);
  assign used_ext = CW'(used_r);
  assign used_zero = (used_r == '0);

  always_comb begin
    itm = (state_r == S_IDLE) ? head : cur_r;
    i_chars = {itm.g2, itm.g1, itm.g0};
    n_cnt  = (r_cnt == CMAX) ? r_cnt : r_cnt + 1'b1;
    n_scnt = (itm.susp && r_scnt != CMAX) ? r_scnt + 1'b1 : r_scnt;

    state_nxt = state_r;
    cur_nxt = cur_r;
    scan_nxt = scan_r;
    used_nxt = used_r;
    sum_nxt = sum_r;
    ssum_nxt = ssum_r;
    pop = 1'b0;
    we = 1'b0;
    waddr = scan_r;
    wdata = {n_scnt, n_cnt, r_chars};
    raddr = '0;
    strobe_nxt = 1'b0;
    pres_nxt = 1'b0;
    drop_nxt = 1'b0;
    gram_nxt = '0;
    occ_nxt = '0;
    socc_nxt = '0;

    // A fresh sequence goes to the next free slot, or is dropped when full.
    if ((state_r == S_IDLE && !empty && head.op == OP_CHAR && head.count_en
         && used_zero)
        || (state_r == S_SCAN && r_chars != i_chars
            && {1'b0, scan_r} + 1'b1 == {1'b0, used_r})) begin
      strobe_nxt = 1'b1;
      if (used_r != FULL_CNT) begin
        we = 1'b1;
        waddr = AW'(used_r);
        wdata = {{(COUNT_BITS-1){1'b0}}, itm.susp, COUNT_BITS'(1), i_chars};
        used_nxt = used_r + 1'b1;
        sum_nxt = (sum_r == CMAX) ? sum_r : sum_r + 1'b1;
        ssum_nxt = (itm.susp && ssum_r != CMAX) ? ssum_r + 1'b1 : ssum_r;
        pres_nxt = 1'b1;
        gram_nxt = i_chars;
        occ_nxt = COUNT_BITS'(1);
        socc_nxt = COUNT_BITS'(itm.susp);
      end else begin
        drop_nxt = 1'b1;
      end
      state_nxt = S_IDLE;
    end

    case (state_r)
      S_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          cur_nxt = head;
          if (head.op == OP_READ) begin
            if (idx_ext < used_ext) begin
              raddr = AW'(idx_ext);
              state_nxt = S_RDWAIT;
            end else begin
              strobe_nxt = 1'b1;
            end
          end else if (!head.count_en) begin
            strobe_nxt = 1'b1;
          end else if (!used_zero) begin
            raddr = '0;
            scan_nxt = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (r_chars == i_chars) begin
          we = 1'b1;
          waddr = scan_r;
          sum_nxt = (sum_r == CMAX) ? sum_r : sum_r + 1'b1;
          ssum_nxt = (itm.susp && ssum_r != CMAX) ? ssum_r + 1'b1 : ssum_r;
          strobe_nxt = 1'b1;
          pres_nxt = 1'b1;
          gram_nxt = r_chars;
          occ_nxt = n_cnt;
          socc_nxt = n_scnt;
          state_nxt = S_IDLE;
        end else if ({1'b0, scan_r} + 1'b1 != {1'b0, used_r}) begin
          scan_nxt = scan_r + 1'b1;
          raddr = scan_r + 1'b1;
        end
      end
      S_RDWAIT: begin
        strobe_nxt = 1'b1;
        pres_nxt = 1'b1;
        gram_nxt = r_chars;
        occ_nxt = r_cnt;
        socc_nxt = r_scnt;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r <= '0;
      sum_r <= '0;
      ssum_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r <= used_nxt;
      sum_r <= sum_nxt;
      ssum_r <= ssum_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    scan_r <= scan_nxt;
    if (strobe_nxt) begin
      pres_r <= pres_nxt;
      drop_r <= drop_nxt;
      gram_r <= gram_nxt;
      occ_r <= occ_nxt;
      socc_r <= socc_nxt;
    end
  end

  logic [COUNT_BITS+OUT_CNT_W-1:0] occ_x, socc_x, sum_x, ssum_x;
  logic [UW+USED_OUT_W-1:0]        used_x;

  assign occ_x  = {{OUT_CNT_W{1'b0}}, occ_r};
  assign socc_x = {{OUT_CNT_W{1'b0}}, socc_r};
  assign sum_x  = {{OUT_CNT_W{1'b0}}, sum_r};
  assign ssum_x = {{OUT_CNT_W{1'b0}}, ssum_r};
  assign used_x = {{USED_OUT_W{1'b0}}, used_r};

  assign out_strobe              = strobe_r;
  assign out_entry_present       = pres_r;
  assign out_dropped_full        = drop_r;
  assign out_gram_first          = gram_r[CHAR_W-1:0];
  assign out_gram_second         = gram_r[2*CHAR_W-1:CHAR_W];
  assign out_gram_third          = gram_r[GRAM_W-1:2*CHAR_W];
  assign out_occurrences         = occ_x[OUT_CNT_W-1:0];
  assign out_suspect_occurrences = socc_x[OUT_CNT_W-1:0];
  assign out_grand_total         = sum_x[OUT_CNT_W-1:0];
  assign out_grand_suspect       = ssum_x[OUT_CNT_W-1:0];
  assign out_distinct_used       = used_x[USED_OUT_W-1:0];

endmodule

FILE: rtl/char_ngram_histogram.sv
// A read of an empty or out-of-range slot, or an uncounted character, is answered straight from
// the queue head; a read of a stored slot waits for the table read; a counted character first
// scans the used slots in order, then is counted in its slot or placed in the next free one.
// The back part finishes each item before it pops the next one, so a new item waits; a two-item
// queue lets start run ahead.
// Reset (rst_n low, synchronous) clears the fill count; the receiver cannot stall.
module char_ngram_histogram import cng_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int MAX_GRAM      = MAX_GRAM_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_wdata,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_opcode,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic                  in_char_suspect,
  input  logic                  in_file_start,
  input  logic [IDX_W-1:0]      in_read_index,
  output logic                  out_strobe,
  output logic                  out_entry_present,
  output logic [CHAR_W-1:0]     out_gram_first,
  output logic [CHAR_W-1:0]     out_gram_second,
  output logic [CHAR_W-1:0]     out_gram_third,
  output logic [OUT_CNT_W-1:0]  out_occurrences,
  output logic [OUT_CNT_W-1:0]  out_suspect_occurrences,
  output logic [OUT_CNT_W-1:0]  out_grand_total,
  output logic [OUT_CNT_W-1:0]  out_grand_suspect,
  output logic [USED_OUT_W-1:0] out_distinct_used,
  output logic                  out_dropped_full
);

  cng_item_t f_item, q_head;
  logic      accept, q_full, q_empty, q_pop;

  assign busy   = q_full;
  assign accept = start && !q_full;

  cng_front #(.MAX_GRAM(MAX_GRAM)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .accept(accept), .in_opcode(in_opcode), .in_char_code(in_char_code),
    .in_char_suspect(in_char_suspect), .in_file_start(in_file_start),
    .in_read_index(in_read_index), .item(f_item)
  );

  cng_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(accept), .push_item(f_item),
    .pop(q_pop), .head(q_head), .empty(q_empty), .full(q_full)
  );

  cng_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .head(q_head), .empty(q_empty), .pop(q_pop),
    .out_strobe(out_strobe), .out_entry_present(out_entry_present),
    .out_gram_first(out_gram_first), .out_gram_second(out_gram_second),
    .out_gram_third(out_gram_third), .out_occurrences(out_occurrences),
    .out_suspect_occurrences(out_suspect_occurrences),
    .out_grand_total(out_grand_total), .out_grand_suspect(out_grand_suspect),
    .out_distinct_used(out_distinct_used), .out_dropped_full(out_dropped_full)
  );

endmodule
